// File: rtl/tsld_pkg.sv
// ----------------------------------------------------------------------------
// tsld_pkg
// Shared types, constants and the bar pattern helper function of the
// tachometer shift-light display core.
// ----------------------------------------------------------------------------
package tsld_pkg;

	localparam int COUNT_W    = 8;
	localparam int DATA_W     = 8;
	localparam int QUO_W      = 16;
	localparam int BAR_W      = 10;
	localparam int FLAG_W     = 6;
	localparam int FRAME_BITS = 24;
	localparam int BIT_CNT_W  = 5;
	localparam int STEP_CNT_W = 4;
	localparam int PHASE_W    = 3;
	localparam int NUM_REGS   = 7;
	localparam int CFG_IDX_W  = 3;

	localparam logic [BAR_W-1:0]  BAR_ALL   = 10'h3ff;
	localparam logic [FLAG_W-1:0] FLAGS     = 6'b001111;
	localparam logic [QUO_W-1:0]  RATIO_TOP = 16'd256;
	localparam logic [QUO_W-1:0]  RATIO_R5  = 16'd200;
	localparam logic [QUO_W-1:0]  RATIO_R4  = 16'd150;
	localparam logic [QUO_W-1:0]  RATIO_R3  = 16'd100;
	localparam logic [QUO_W-1:0]  RATIO_R2  = 16'd50;
	localparam logic [COUNT_W-1:0] BLINK_MIN_COUNT = 8'd90;
	localparam logic [PHASE_W-1:0] PHASE_INVERT    = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_WRAP      = 3'd4;
	localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX  = BIT_CNT_W'(FRAME_BITS - 1);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_ONE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_TWO    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_THREE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_FOUR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_FIVE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_SIX    = 3'd6;
	localparam logic [DATA_W-1:0]    SPEED_RESET     = 8'd40;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	typedef struct packed {
		logic                start;
		logic [QUO_W-1:0]    dividend;
		logic [COUNT_W-1:0]  divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_status_t;

	// Threshold ladder of the rpm bar: the highest threshold reached clears
	// its segment, all segments stay high below the lowest threshold.
	function automatic logic [BAR_W-1:0] bar_pattern(input logic [COUNT_W-1:0] v);
		logic [BAR_W-1:0] bar;
		bar = BAR_ALL;
		if (v >= 8'd130)      bar[9] = 1'b0;
		else if (v >= 8'd120) bar[8] = 1'b0;
		else if (v >= 8'd110) bar[7] = 1'b0;
		else if (v >= 8'd100) bar[6] = 1'b0;
		else if (v >= 8'd90)  bar[5] = 1'b0;
		else if (v >= 8'd80)  bar[4] = 1'b0;
		else if (v >= 8'd70)  bar[3] = 1'b0;
		else if (v >= 8'd60)  bar[2] = 1'b0;
		else if (v >= 8'd40)  bar[1] = 1'b0;
		else if (v >= 8'd20)  bar[0] = 1'b0;
		return bar;
	endfunction

endpackage

// File: rtl/tacho_shift_light_display_core.sv
// ----------------------------------------------------------------------------
// tacho_shift_light_display_core
// Tachometer bar and shift-light display frame generator.
// ----------------------------------------------------------------------------
// Each input transaction on the s_ channel carries the pulse count of one
// tick period. The core builds a 24-bit display frame (gear code, six flag
// bits, ten active-low bar segments) and sends it MSB first as 24 output
// transactions on the m_ channel, one frame bit each; m_tlast marks the
// 24th bit. The gear ratio speed*256/count comes from a restoring divider
// that produces one quotient bit per cycle; the frame is loaded when the
// divider is done. A new count is taken only once the last frame bit has
// gone out and the core is back in idle, as s_tready is high only in idle.
// When the receiver holds m_tready low, the current bit simply waits in
// the frame register until it is accepted.
// Configuration writes (cfg_index 0 speed, 1..6 gear codes) are always
// ready and should only be issued while idle; indexes above 6 are dropped.
// Reset clears the shift-light phase and sets speed to 40, gear codes to 0.
// ----------------------------------------------------------------------------
module tacho_shift_light_display_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,    // [7:0] pulse_count
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,    // [0] serial_bit, [7:1] zero
	output logic                           m_tlast,    // last_bit
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsld_pkg::DATA_W-1:0]    cfg_data
);
	import tsld_pkg::*;

	state_t                    state_q;
	logic [DATA_W-1:0]         cfg_q [NUM_REGS];
	logic [COUNT_W-1:0]        count_q;
	logic [PHASE_W-1:0]        phase_q;
	logic [FRAME_BITS-1:0]     frame_q;
	logic [BIT_CNT_W-1:0]      bit_cnt_q;
	div_ctrl_t                 div_ctrl;
	div_status_t               div_status;
	logic                      in_fire;
	logic                      out_fire;
	logic                      zero;
	logic [CFG_IDX_W-1:0]      gear_sel;
	logic                      blink;
	logic [BAR_W-1:0]          bar;
	logic [PHASE_W-1:0]        phase_inc;
	logic [PHASE_W-1:0]        phase_next;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_SEND);
	assign m_tdata   = {7'b0, frame_q[FRAME_BITS-1]};
	assign m_tlast   = (bit_cnt_q == LAST_BIT_IDX);
	assign in_fire   = s_tvalid && s_tready;
	assign out_fire  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
			cfg_q[REG_SPEED] <= SPEED_RESET;
		end else if (cfg_valid && cfg_ready && cfg_index <= REG_GEAR_SIX) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	assign div_ctrl.start    = in_fire;
	assign div_ctrl.dividend = {cfg_q[REG_SPEED], 8'b0};
	assign div_ctrl.divisor  = s_tdata;

	tsld_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.status (div_status)
	);

	// Frame assembly once the quotient is ready.
	always_comb begin
		zero = (count_q == '0);
		if (zero || div_status.quotient > RATIO_TOP)     gear_sel = REG_GEAR_SIX;
		else if (div_status.quotient > RATIO_R5)         gear_sel = REG_GEAR_FIVE;
		else if (div_status.quotient > RATIO_R4)         gear_sel = REG_GEAR_FOUR;
		else if (div_status.quotient > RATIO_R3)         gear_sel = REG_GEAR_THREE;
		else if (div_status.quotient > RATIO_R2)         gear_sel = REG_GEAR_TWO;
		else                                             gear_sel = REG_GEAR_ONE;

		blink     = (count_q > BLINK_MIN_COUNT) && !zero && (div_status.quotient < RATIO_R5);
		bar       = bar_pattern(count_q);
		phase_inc = phase_q + 1'b1;
		if (blink) begin
			if (phase_q > PHASE_INVERT) bar = ~bar;
			phase_next = (phase_inc > PHASE_WRAP) ? '0 : phase_inc;
		end else begin
			phase_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			bit_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_status.done) begin
						phase_q   <= phase_next;
						bit_cnt_q <= '0;
						state_q   <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (out_fire) begin
						bit_cnt_q <= bit_cnt_q + 1'b1;
						if (m_tlast) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) count_q <= s_tdata;
		if (state_q == ST_DIV && div_status.done) begin
			frame_q <= {cfg_q[gear_sel], FLAGS, bar};
		end else if (out_fire) begin
			frame_q <= {frame_q[FRAME_BITS-2:0], 1'b0};
		end
	end

	a_ready_not_sending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while a frame is being sent");

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_DIV && div_status.busy))
		else $error("accepted count did not start the divider");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_tlast) |=> s_tready)
		else $error("core not idle after the last frame bit");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_WRAP)
		else $error("shift-light phase out of range");

	a_first_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_status.done) |=> (m_tvalid && bit_cnt_q == '0))
		else $error("frame did not start at its first bit");

endmodule

// File: rtl/tsld_div.sv
// ----------------------------------------------------------------------------
// tsld_div
// Restoring divider, one quotient bit per cycle, 16 steps per division.
// ----------------------------------------------------------------------------
module tsld_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsld_pkg::div_ctrl_t   ctrl,
	output tsld_pkg::div_status_t status
);
	import tsld_pkg::*;

	logic [QUO_W-1:0]      quo_q;
	logic [COUNT_W-1:0]    rem_q;
	logic [COUNT_W-1:0]    divisor_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_W:0]      trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = (trial >= {1'b0, divisor_q});

	// A zero divisor always fits, so the quotient comes out all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q     <= ctrl.dividend;
			rem_q     <= '0;
			divisor_q <= ctrl.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QUO_W-2:0], fits};
			if (fits) rem_q <= COUNT_W'(trial - {1'b0, divisor_q});
			else      rem_q <= trial[COUNT_W-1:0];
		end
	end

	assign status.busy     = busy_q;
	assign status.done     = done_q;
	assign status.quotient = quo_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !ctrl.start && step_q == '1) |=> done_q)
		else $error("divider missed its done pulse");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> (busy_q && step_q == '0))
		else $error("divider did not start");

endmodule
